@@ design/i2cseq_pkg.sv @@
// Shared types, bus operation codes and status codes for the I2C EEPROM sequencer.
package i2cseq_pkg;

    localparam int PAGE_BYTES = 64;
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam logic [15:0] ADDR_LIMIT = 16'd32767;

    localparam logic [1:0] ACT_OPEN  = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_REPLY = 2'd2;

    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_RESTART   = 3'd2;
    localparam logic [2:0] OP_STOP      = 3'd3;
    localparam logic [2:0] OP_WRITE     = 3'd4;
    localparam logic [2:0] OP_READ_ACK  = 3'd5;
    localparam logic [2:0] OP_READ_NACK = 3'd6;

    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_ZERO_LEN = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR = 3'd3;
    localparam logic [2:0] ST_RD_FAIL  = 3'd4;
    localparam logic [2:0] ST_WR_NACK  = 3'd5;

    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [2:0] bus_op;
        logic [7:0] bus_byte;
        logic [7:0] read_data;
        logic       read_valid;
        logic [2:0] status;
    } t_result;

    // Everything one accepted item causes on the bus side
    typedef struct packed {
        logic [1:0]                 cnt;
        t_result [MAX_RES-1:0]      res;
    } t_bundle;

    function automatic t_result mk_res(logic [2:0] op, logic [7:0] byte_v,
                                       logic [7:0] rdata, logic rvalid,
                                       logic [2:0] status);
        t_result r;
        r.bus_op     = op;
        r.bus_byte   = byte_v;
        r.read_data  = rdata;
        r.read_valid = rvalid;
        r.status     = status;
        return r;
    endfunction

endpackage

@@ design/i2cseq_front.sv @@
// Front end: accepts items, tracks the transfer phase and builds the bus operation bundle.
module i2cseq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_action,
    input  logic                 i_is_read,
    input  logic [6:0]           i_chip_addr,
    input  logic [14:0]          i_start_addr,
    input  logic [14:0]          i_length,
    input  logic [7:0]           i_write_byte,
    input  logic                 i_bus_nack,
    input  logic [7:0]           i_bus_read_byte,
    input  logic                 i_q_full,
    output logic                 o_push,
    output i2cseq_pkg::t_bundle  o_bundle
);
    import i2cseq_pkg::*;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_R_CW   = 4'd1;
    localparam logic [3:0] PH_R_HI   = 4'd2;
    localparam logic [3:0] PH_R_LO   = 4'd3;
    localparam logic [3:0] PH_R_CR   = 4'd4;
    localparam logic [3:0] PH_R_DATA = 4'd5;
    localparam logic [3:0] PH_W_CW   = 4'd6;
    localparam logic [3:0] PH_W_HI   = 4'd7;
    localparam logic [3:0] PH_W_LO   = 4'd8;
    localparam logic [3:0] PH_W_DATA = 4'd9;
    localparam logic [3:0] PH_W_ACK  = 4'd10;
    localparam logic [3:0] PH_W_POLL = 4'd11;

    logic [3:0]  r_phase, n_phase;
    logic [6:0]  r_dev,   n_dev;
    logic [14:0] r_addr,  n_addr;
    logic [14:0] r_left,  n_left;
    logic        r_err,   n_err;

    t_bundle     bun;
    logic        accept;
    logic [15:0] end_addr;
    logic [14:0] addr_inc;
    logic [14:0] left_dec;
    logic        err_now;
    logic [7:0]  ctrl_w;
    logic [7:0]  ctrl_r;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign end_addr = {1'b0, i_start_addr} + {1'b0, i_length};
    assign addr_inc = r_addr + 15'd1;
    assign left_dec = r_left - 15'd1;
    assign err_now  = r_err | i_bus_nack;
    assign ctrl_w   = {r_dev, 1'b0};
    assign ctrl_r   = {r_dev, 1'b1};

    always_comb begin
        n_phase = r_phase;
        n_dev   = r_dev;
        n_addr  = r_addr;
        n_left  = r_left;
        n_err   = r_err;
        bun     = '0;
        case (i_action)
            ACT_OPEN: begin
                n_phase = PH_IDLE;
                bun.cnt = 2'd1;
                if (i_length == 15'd0) begin
                    bun.res[0] = mk_res(OP_NONE, 8'd0, 8'd0, 1'b0, ST_ZERO_LEN);
                end else if (end_addr > ADDR_LIMIT) begin
                    bun.res[0] = mk_res(OP_NONE, 8'd0, 8'd0, 1'b0, ST_BAD_ADDR);
                end else begin
                    n_dev      = i_chip_addr;
                    n_addr     = i_start_addr;
                    n_left     = i_length;
                    n_err      = 1'b0;
                    n_phase    = i_is_read ? PH_R_CW : PH_W_CW;
                    bun.cnt    = 2'd2;
                    bun.res[0] = mk_res(OP_START, 8'd0, 8'd0, 1'b0, ST_BUSY);
                    bun.res[1] = mk_res(OP_WRITE, {i_chip_addr, 1'b0}, 8'd0, 1'b0,
                                        ST_BUSY);
                end
            end
            ACT_DATA: begin
                if (r_phase == PH_W_DATA) begin
                    bun.cnt    = 2'd1;
                    bun.res[0] = mk_res(OP_WRITE, i_write_byte, 8'd0, 1'b0, ST_BUSY);
                    n_phase    = PH_W_ACK;
                end
            end
            ACT_REPLY: begin
                case (r_phase)
                    PH_R_CW, PH_W_CW: begin
                        n_err      = err_now;
                        bun.cnt    = 2'd1;
                        bun.res[0] = mk_res(OP_WRITE, {1'b0, r_addr[14:8]}, 8'd0, 1'b0,
                                            ST_BUSY);
                        n_phase    = (r_phase == PH_R_CW) ? PH_R_HI : PH_W_HI;
                    end
                    PH_R_HI, PH_W_HI: begin
                        n_err      = err_now;
                        bun.cnt    = 2'd1;
                        bun.res[0] = mk_res(OP_WRITE, r_addr[7:0], 8'd0, 1'b0, ST_BUSY);
                        n_phase    = (r_phase == PH_R_HI) ? PH_R_LO : PH_W_LO;
                    end
                    PH_R_LO: begin
                        n_err      = err_now;
                        bun.cnt    = 2'd2;
                        bun.res[0] = mk_res(OP_RESTART, 8'd0, 8'd0, 1'b0, ST_BUSY);
                        bun.res[1] = mk_res(OP_WRITE, ctrl_r, 8'd0, 1'b0, ST_BUSY);
                        n_phase    = PH_R_CR;
                    end
                    PH_W_LO: begin
                        n_err   = err_now;
                        n_phase = PH_W_DATA;
                    end
                    PH_R_CR: begin
                        n_err   = err_now;
                        bun.cnt = 2'd1;
                        if (err_now) begin
                            bun.res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0, ST_RD_FAIL);
                            n_phase    = PH_IDLE;
                        end else begin
                            bun.res[0] = mk_res((r_left > 15'd1) ? OP_READ_ACK
                                                                 : OP_READ_NACK,
                                                8'd0, 8'd0, 1'b0, ST_BUSY);
                            n_phase    = PH_R_DATA;
                        end
                    end
                    PH_R_DATA: begin
                        n_left  = left_dec;
                        bun.cnt = 2'd1;
                        if (left_dec == 15'd0) begin
                            bun.res[0] = mk_res(OP_STOP, 8'd0, i_bus_read_byte, 1'b1,
                                                ST_DONE);
                            n_phase    = PH_IDLE;
                        end else begin
                            bun.res[0] = mk_res((left_dec > 15'd1) ? OP_READ_ACK
                                                                   : OP_READ_NACK,
                                                8'd0, i_bus_read_byte, 1'b1, ST_BUSY);
                        end
                    end
                    PH_W_ACK: begin
                        n_err  = err_now;
                        n_left = left_dec;
                        n_addr = addr_inc;
                        if (left_dec == 15'd0) begin
                            bun.cnt    = 2'd1;
                            bun.res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0,
                                                err_now ? ST_WR_NACK : ST_DONE);
                            n_phase    = PH_IDLE;
                        end else if (addr_inc[PAGE_BITS-1:0] == '0) begin
                            // page boundary: close the write cycle and start polling
                            bun.cnt    = 2'd3;
                            bun.res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0, ST_BUSY);
                            bun.res[1] = mk_res(OP_START, 8'd0, 8'd0, 1'b0, ST_BUSY);
                            bun.res[2] = mk_res(OP_WRITE, ctrl_w, 8'd0, 1'b0, ST_BUSY);
                            n_phase    = PH_W_POLL;
                        end else begin
                            n_phase = PH_W_DATA;
                        end
                    end
                    PH_W_POLL: begin
                        if (i_bus_nack) begin
                            bun.cnt    = 2'd2;
                            bun.res[0] = mk_res(OP_RESTART, 8'd0, 8'd0, 1'b0, ST_BUSY);
                            bun.res[1] = mk_res(OP_WRITE, ctrl_w, 8'd0, 1'b0, ST_BUSY);
                        end else begin
                            bun.cnt    = 2'd3;
                            bun.res[0] = mk_res(OP_STOP, 8'd0, 8'd0, 1'b0, ST_BUSY);
                            bun.res[1] = mk_res(OP_START, 8'd0, 8'd0, 1'b0, ST_BUSY);
                            bun.res[2] = mk_res(OP_WRITE, ctrl_w, 8'd0, 1'b0, ST_BUSY);
                            n_phase    = PH_W_CW;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    assign o_push   = accept && (bun.cnt != 2'd0);
    assign o_bundle = bun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_dev   <= '0;
            r_addr  <= '0;
            r_left  <= '0;
            r_err   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_dev   <= n_dev;
            r_addr  <= n_addr;
            r_left  <= n_left;
            r_err   <= n_err;
        end
    end

endmodule

@@ design/i2cseq_queue.sv @@
// Two-entry bundle queue between the front end and the bus operation issuer.
module i2cseq_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  i2cseq_pkg::t_bundle  i_bundle,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output i2cseq_pkg::t_bundle  o_bundle
);
    import i2cseq_pkg::*;

    t_bundle    r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full   = (r_cnt == 2'd2);
    assign o_empty  = (r_cnt == 2'd0);
    assign o_bundle = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ design/i2cseq_back.sv @@
// Back end: issues the bus operations of each bundle one per transfer and marks the last.
module i2cseq_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  i2cseq_pkg::t_bundle  i_bundle,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_bus_op,
    output logic [7:0]           o_bus_byte,
    output logic [7:0]           o_read_data,
    output logic                 o_read_valid,
    output logic [2:0]           o_status,
    output logic                 o_last
);
    import i2cseq_pkg::*;

    t_bundle    r_bun;
    logic [1:0] r_idx;
    logic       r_busy;
    t_result    cur;
    logic       is_last;
    logic       done;

    assign cur     = r_bun.res[r_idx];
    assign is_last = (r_idx == (r_bun.cnt - 2'd1));
    assign done    = r_busy && i_ready && is_last;
    assign o_pop   = !i_q_empty && (!r_busy || done);

    assign o_valid      = r_busy;
    assign o_bus_op     = cur.bus_op;
    assign o_bus_byte   = cur.bus_byte;
    assign o_read_data  = cur.read_data;
    assign o_read_valid = cur.read_valid;
    assign o_status     = cur.status;
    assign o_last       = is_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bun <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

@@ design/i2c_eeprom_transfer_sequencer_core.sv @@
// Top level of the I2C serial EEPROM transfer sequencer.
// Usage: one input channel (i_valid/o_ready) carries opens, write data bytes and bus
// replies; one output channel (o_valid/i_ready) carries bus operations, received read
// data and the transfer status, one result per transfer, o_last on the final result
// caused by an input item. Items that cause nothing produce no output transfer.
// An open returns start plus the control byte, or a single status result if the length
// is zero or the range runs past the address limit. Bus replies step the phase.
// The results of an accepted item pass through the queue, then the output register,
// before the first of them can be taken.
// Throughput: the front end takes one item per cycle while the two-entry bundle queue
// has room; the output register issues one result per cycle while i_ready is high,
// and an item causes one to three results.
// When the receiver stalls, results wait in the output register, then the queue, then
// o_ready drops. Reset clears the phase, the queue and the output; no item is in flight
// afterwards and o_ready is high as soon as reset is released.
module i2c_eeprom_transfer_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic        i_is_read,
    input  logic [6:0]  i_chip_addr,
    input  logic [14:0] i_start_addr,
    input  logic [14:0] i_length,
    input  logic [7:0]  i_write_byte,
    input  logic        i_bus_nack,
    input  logic [7:0]  i_bus_read_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_bus_op,
    output logic [7:0]  o_bus_byte,
    output logic [7:0]  o_read_data,
    output logic        o_read_valid,
    output logic [2:0]  o_status,
    output logic        o_last
);
    import i2cseq_pkg::*;

    t_bundle push_bun;
    t_bundle head_bun;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;

    i2cseq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_is_read       (i_is_read),
        .i_chip_addr     (i_chip_addr),
        .i_start_addr    (i_start_addr),
        .i_length        (i_length),
        .i_write_byte    (i_write_byte),
        .i_bus_nack      (i_bus_nack),
        .i_bus_read_byte (i_bus_read_byte),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_bundle        (push_bun)
    );

    i2cseq_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bun),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_empty  (q_empty),
        .o_bundle (head_bun)
    );

    i2cseq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_bundle     (head_bun),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_bus_op     (o_bus_op),
        .o_bus_byte   (o_bus_byte),
        .o_read_data  (o_read_data),
        .o_read_valid (o_read_valid),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

@@ design/i2cseq_checker.sv @@
// Port-level assertions for the sequencer core, with the bind that attaches them.
module i2cseq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_bus_op,
    input logic [7:0]  o_bus_byte,
    input logic [7:0]  o_read_data,
    input logic        o_read_valid,
    input logic [2:0]  o_status,
    input logic        o_last
);
    import i2cseq_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

    // a final status only ever closes an item, on a stop or as a lone reply to an open
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_BUSY) |->
            o_last && ((o_bus_op == OP_STOP) || (o_bus_op == OP_NONE)))
        else $error("final status on a non-terminal result");

    a_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_read_valid |-> (o_read_data == 8'd0))
        else $error("read data without read valid");

    a_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_bus_op != OP_WRITE) |-> (o_bus_byte == 8'd0))
        else $error("bus byte on a non-write operation");

endmodule

bind i2c_eeprom_transfer_sequencer_core i2cseq_checker u_i2cseq_checker (.*);
